[rtl/jnea_pkg.sv]
// shared types, constants and the column activity function of the
// normal-equation accumulator; no dependencies
`default_nettype none

package jnea_pkg;

  localparam int MAX_COLUMNS = 8;
  localparam int JAC_W       = 16;
  localparam int PROD_W      = 2 * JAC_W;
  localparam int SUM_W       = 48;
  localparam int COUNT_W     = 4;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int READ_COL_W  = 4;
  localparam int CFG_IDX_W   = 2;

  // read_col code that selects the gradient element
  localparam logic [READ_COL_W-1:0] GRAD_COL = READ_COL_W'(8);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ACCUM = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FROM_COUNT  = 2'd0,
    CFG_TO_COUNT    = 2'd1,
    CFG_FROM_ENABLE = 2'd2,
    CFG_TO_ENABLE   = 2'd3
  } cfg_idx_t;

  // per-cell control: load product register, clear sum, accumulate product
  typedef struct packed {
    logic load;
    logic clr;
    logic add;
  } cell_ctl_t;

  function automatic logic [MAX_COLUMNS-1:0] active_mask(
    input logic [COUNT_W-1:0] from_count,
    input logic [COUNT_W-1:0] to_count,
    input logic               from_enable,
    input logic               to_enable
  );
    logic [COUNT_W-1:0]     fc;
    logic [COUNT_W-1:0]     rem;
    logic [COUNT_W-1:0]     tc;
    logic [COUNT_W-1:0]     lim;
    logic [MAX_COLUMNS-1:0] act;
    fc  = (from_count > COUNT_W'(MAX_COLUMNS)) ? COUNT_W'(MAX_COLUMNS) : from_count;
    rem = COUNT_W'(MAX_COLUMNS) - fc;
    tc  = (to_count > rem) ? rem : to_count;
    lim = fc + tc;
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      if (COUNT_W'(c) < fc) begin
        act[c] = from_enable;
      end else if (COUNT_W'(c) < lim) begin
        act[c] = to_enable;
      end else begin
        act[c] = 1'b0;
      end
    end
    return act;
  endfunction

endpackage

`default_nettype wire

[rtl/jnea_mac_cell.sv]
// one multiply-accumulate cell: registered product, saturating 48-bit sum
// depends on jnea_pkg
`default_nettype none

module jnea_mac_cell
  import jnea_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cell_ctl_t               ctl,
  input  wire logic signed [JAC_W-1:0] a,
  input  wire logic signed [JAC_W-1:0] b,
  output logic signed [SUM_W-1:0]      sum
);

  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W:0]    wide;
  logic signed [SUM_W-1:0]  sum_next;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod <= a * b;
    end
  end

  // one guard bit catches overflow of the add
  always_comb begin
    wide = {sum[SUM_W-1], sum} + (SUM_W+1)'(prod);
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      sum_next = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_next = wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctl.clr) begin
      sum <= '0;
    end else if (ctl.add) begin
      sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

[rtl/jacobian_normal_equation_accum_core.sv]
// top level of the Gauss-Newton normal-equation accumulator
// depends on jnea_pkg and jnea_mac_cell
`default_nettype none

// Usage
//   s_* channel: one item per handshake. s_tuser is the operation
//   (clear, accumulate a row, read one element). s_tdata carries the eight
//   Jacobian entries, the residual and the read indexes.
//   m_* channel: one item per read, holding the 48-bit sum and a flag set
//   when the element lies in an inactive or disabled block (value zero).
//   Clear, accumulate and the unused operation code give no item.
//   cfg_* channel: register writes, always ready; write only while idle.
// Timing
//   three-stage pipe: input register, product register (44 parallel
//   16x16 multipliers), then saturating accumulate or read-out into the
//   output register. A read item passes the input and product registers.
//   One item per cycle is sustained unless a held read result stalls m_*;
//   the product stage and the accumulators set the rate, each updated once per cycle.
//   Items stay in order, so a read sees every accumulate accepted before it.
// Reset and stalls
//   rst clears the pipe valids, the registers to their defaults and all
//   sums to zero. When m_tready is low a held result blocks only a read in
//   stage 2; clears and accumulates keep moving, and s_tready drops once
//   the input register behind a blocked read is full.

module jacobian_normal_equation_accum_core
  import jnea_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  // input items
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // jac_0..jac_7 [127:0], residual_value [143:128], read_row [146:144],
  // read_col [150:147], zero pad [151]
  input  wire logic [151:0] s_tdata,
  // operation [1:0]
  input  wire logic [1:0]   s_tuser,
  // result items
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // value [47:0]
  output logic [47:0]       m_tdata,
  // outside [0]
  output logic              m_tuser,
  // register writes
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COUNT_W-1:0]   cfg_data
);

  localparam int RES_LSB = MAX_COLUMNS * JAC_W;
  localparam int ROW_LSB = RES_LSB + JAC_W;
  localparam int COL_LSB = ROW_LSB + COL_W;

  // configuration registers
  logic [COUNT_W-1:0] from_count;
  logic [COUNT_W-1:0] to_count;
  logic               from_enable;
  logic               to_enable;
  logic [MAX_COLUMNS-1:0] act;

  // stage 1: input register
  logic                    valid1;
  logic [1:0]              op1;
  logic signed [JAC_W-1:0] jac1 [MAX_COLUMNS];
  logic signed [JAC_W-1:0] res1;
  logic [COL_W-1:0]        row1;
  logic [READ_COL_W-1:0]   col1;

  // stage 2: products held in the cells
  logic                  valid2;
  logic [1:0]            op2;
  logic [COL_W-1:0]      row2;
  logic [READ_COL_W-1:0] col2;

  // handshake between stages
  logic out_free;
  logic s2_go;
  logic s2_free;
  logic s1_go;

  // sums; lower triangle mirrors the upper
  logic signed [SUM_W-1:0] hsum [MAX_COLUMNS][MAX_COLUMNS];
  logic signed [SUM_W-1:0] gsum [MAX_COLUMNS];

  // read-out
  logic signed [SUM_W-1:0] rd_value;
  logic                    rd_outside;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      from_count  <= COUNT_W'(4);
      to_count    <= COUNT_W'(4);
      from_enable <= 1'b1;
      to_enable   <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FROM_COUNT:  from_count  <= cfg_data;
        CFG_TO_COUNT:    to_count    <= cfg_data;
        CFG_FROM_ENABLE: from_enable <= cfg_data[0];
        CFG_TO_ENABLE:   to_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // the user must change config only while idle (not enforced by the block), so one mask serves every stage
  assign act = active_mask(from_count, to_count, from_enable, to_enable);

  // a stage moves on when the one after it has room
  assign out_free = !m_tvalid || m_tready;
  assign s2_go    = valid2 && ((op2 != OP_READ) || out_free);
  assign s2_free  = !valid2 || s2_go;
  assign s1_go    = valid1 && s2_free;
  assign s_tready = !valid1 || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (s_tready) begin
      valid1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op1  <= s_tuser;
      res1 <= s_tdata[RES_LSB +: JAC_W];
      row1 <= s_tdata[ROW_LSB +: COL_W];
      col1 <= s_tdata[COL_LSB +: READ_COL_W];
      for (int c = 0; c < MAX_COLUMNS; c++) begin
        jac1[c] <= s_tdata[c*JAC_W +: JAC_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (s2_free) begin
      valid2 <= s1_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      op2  <= op1;
      row2 <= row1;
      col2 <= col1;
    end
  end

  // hessian cells on and above the diagonal, gradient cell per column
  for (genvar i = 0; i < MAX_COLUMNS; i++) begin : g_row
    cell_ctl_t gctl;
    assign gctl.load = s1_go;
    assign gctl.clr  = s2_go && (op2 == OP_CLEAR);
    assign gctl.add  = s2_go && (op2 == OP_ACCUM) && act[i];

    jnea_mac_cell u_grad (
      .clk (clk),
      .rst (rst),
      .ctl (gctl),
      .a   (jac1[i]),
      .b   (res1),
      .sum (gsum[i])
    );

    for (genvar j = 0; j < MAX_COLUMNS; j++) begin : g_col
      if (j >= i) begin : g_upper
        cell_ctl_t hctl;
        assign hctl.load = s1_go;
        assign hctl.clr  = s2_go && (op2 == OP_CLEAR);
        assign hctl.add  = s2_go && (op2 == OP_ACCUM) && act[i] && act[j];

        jnea_mac_cell u_hess (
          .clk (clk),
          .rst (rst),
          .ctl (hctl),
          .a   (jac1[i]),
          .b   (jac1[j]),
          .sum (hsum[i][j])
        );
      end else begin : g_lower
        assign hsum[i][j] = hsum[j][i];
      end
    end
  end

  // element select for a read in stage 2
  always_comb begin
    rd_value   = '0;
    rd_outside = 1'b1;
    if (act[row2]) begin
      if (col2 == GRAD_COL) begin
        rd_value   = gsum[row2];
        rd_outside = 1'b0;
      end else if ((col2 < READ_COL_W'(MAX_COLUMNS)) && act[col2[COL_W-1:0]]) begin
        rd_value   = hsum[row2][col2[COL_W-1:0]];
        rd_outside = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s2_go && (op2 == OP_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_go && (op2 == OP_READ)) begin
      m_tdata <= rd_value;
      m_tuser <= rd_outside;
    end
  end

`ifndef SYNTH
  // a completing read always lands in the output register
  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    (s2_go && (op2 == OP_READ)) |=> m_tvalid)
    else $error("read left stage 2 without producing a result");

  // an element outside the active blocks reads as zero
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("outside element with nonzero value");

  // a completed clear leaves the sums at zero (checked on gsum[0] and hsum[0][0])
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (s2_go && (op2 == OP_CLEAR)) |=> ((gsum[0] == '0) && (hsum[0][0] == '0)))
    else $error("sums not zero after clear");

  // a stalled stage 2 item is not dropped
  a_stage2_holds: assert property (@(posedge clk) disable iff (rst)
    (valid2 && !s2_go) |=> valid2)
    else $error("stage 2 item lost while stalled");
`endif

endmodule

`default_nettype wire
